// ===== rtl/dtf_pkg.sv =====
// Shared types, constants and elaboration-time sine table builder for the DDS tone block.
package dtf_pkg;

    localparam int AMP_W      = 11;
    localparam int SINE_W     = 12;
    localparam int SAMPLE_W   = 12;
    localparam int CTRL_W     = 4;
    localparam int PHASE_W    = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [AMP_W-1:0]    FULL_AMPLITUDE  = 11'd2047;
    localparam logic [SAMPLE_W-1:0] DAC_MIDSCALE    = 12'd2048;
    localparam logic [CTRL_W-1:0]   CTRL_RESET      = 4'd3;
    localparam logic [AMP_W-1:0]    FADE_STEP_RESET = 11'd103;

    localparam logic [63:0] PI_FIXED   = 64'h3243F6A8885A308D;
    localparam int          FRAC_BITS  = 60;
    localparam int          TAYLOR_N   = 14;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DAC_CTRL  = 8'd0,
        CFG_FADE_STEP = 8'd1
    } cfg_index_t;

    typedef enum logic {
        MODE_SAMPLE = 1'b0,
        MODE_FADE   = 1'b1
    } mode_t;

    typedef struct packed {
        logic [CTRL_W-1:0] dac_ctrl;
        logic [AMP_W-1:0]  fade_step;
    } dtf_cfg_t;

    // Shift-subtract divide, used only while building the table.
    function automatic logic [63:0] dtf_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [63:0] dtf_fx_mul(input logic [63:0] x, input logic [63:0] y);
        logic [127:0] p;
        p = {64'd0, x} * {64'd0, y};
        return p[FRAC_BITS+63:FRAC_BITS];
    endfunction

    function automatic logic [63:0] dtf_fx_frac(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] res;
        res = '0;
        for (int k = 0; k < FRAC_BITS; k++)
        begin
            num = {num[62:0], 1'b0};
            res = {res[62:0], 1'b0};
            if (num >= den)
            begin
                num    = num - den;
                res[0] = 1'b1;
            end
        end
        return res;
    endfunction

    // trunc(FULL_AMPLITUDE * sin(i * 6.283 / depth)) in 60-bit fixed point
    function automatic logic signed [SINE_W-1:0] dtf_sine_entry(input int unsigned i,
                                                                input int unsigned depth);
        logic [63:0] n;
        logic [63:0] d;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] a;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] mag;
        logic [63:0] m;
        logic        neg;
        n   = 64'(i) * 64'd6283;
        d   = 64'd1000 * 64'(depth);
        q   = dtf_udiv(n, d);
        r   = n - q * d;
        a   = (q << FRAC_BITS) + dtf_fx_frac(r, d);
        neg = 1'b0;
        for (int j = 0; j < 2; j++)
        begin
            if (a >= PI_FIXED)
            begin
                a   = a - PI_FIXED;
                neg = !neg;
            end
        end
        if (a > (PI_FIXED >> 1))
            a = PI_FIXED - a;
        x2   = dtf_fx_mul(a, a);
        term = a;
        sum  = a;
        for (int k = 1; k <= TAYLOR_N; k++)
        begin
            m    = 64'((2 * k) * (2 * k + 1));
            term = dtf_udiv(dtf_fx_mul(term, x2), m);
            if ((k & 1) != 0)
                sum = sum - term;
            else
                sum = sum + term;
        end
        mag = dtf_fx_mul(sum, 64'(FULL_AMPLITUDE));
        return neg ? -SINE_W'(mag) : SINE_W'(mag);
    endfunction

endpackage

// ===== rtl/dtf_fifo.sv =====
// Small register queue between the front and back parts.
module dtf_fifo
    import dtf_pkg::*;
#(
    parameter int WIDTH = 19,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty,
    output logic             full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(DEPTH));
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full || pop)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("queue read while empty");
`endif

endmodule

// ===== rtl/dtf_front.sv =====
// Front part: takes input transfers, advances phase, applies fades, queues sample work.
module dtf_front
    import dtf_pkg::*;
#(
    parameter int IDX_W = 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     mode,
    input  logic [PHASE_W-1:0]       phase_increment,
    input  logic                     tone_enable,
    input  dtf_cfg_t                 cfg,
    input  logic                     queue_full,
    output logic                     push,
    output logic [IDX_W+AMP_W-1:0]   push_data
);

    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic [AMP_W-1:0]   amp_reg;
    logic [AMP_W-1:0]   amp_next;
    logic [AMP_W:0]     amp_sum;
    logic               accept;

    assign in_ready  = !queue_full;
    assign accept    = in_valid && in_ready;
    assign push      = accept && (mode == MODE_SAMPLE);
    assign push_data = {phase_next[PHASE_W-1 -: IDX_W], amp_reg};

    always_comb
    begin
        phase_next = phase_reg + phase_increment;
        amp_sum    = {1'b0, amp_reg} + {1'b0, cfg.fade_step};
        amp_next   = amp_reg;
        if (tone_enable && amp_reg < FULL_AMPLITUDE)
            amp_next = (amp_sum > {1'b0, FULL_AMPLITUDE}) ? FULL_AMPLITUDE : amp_sum[AMP_W-1:0];
        else if (!tone_enable && amp_reg != '0)
            amp_next = (cfg.fade_step >= amp_reg) ? '0 : amp_reg - cfg.fade_step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            amp_reg   <= FULL_AMPLITUDE;
        end
        else if (accept)
        begin
            if (mode == MODE_SAMPLE)
                phase_reg <= phase_next;
            else
                amp_reg <= amp_next;
        end
    end

`ifndef SYNTHESIS
    a_amp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        amp_reg <= FULL_AMPLITUDE)
        else $error("amplitude beyond full scale");
`endif

endmodule

// ===== rtl/dtf_back.sv =====
// Back part: sine lookup, amplitude scaling and DAC word formatting pipeline.
module dtf_back
    import dtf_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int IDX_W       = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   queue_empty,
    input  logic [IDX_W+AMP_W-1:0] queue_data,
    output logic                   pop,
    input  dtf_cfg_t               cfg,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [15:0]            dac_word,
    output logic [AMP_W-1:0]       current_amplitude
);

    logic signed [SINE_W-1:0] rom_tab [TABLE_DEPTH];

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_rom
        localparam logic signed [SINE_W-1:0] ENTRY = dtf_sine_entry(g, TABLE_DEPTH);
        assign rom_tab[g] = ENTRY;
    end

    logic                     adv;
    logic                     v1_reg;
    logic signed [SINE_W-1:0] sine1_reg;
    logic [AMP_W-1:0]         amp1_reg;
    logic                     v2_reg;
    logic                     neg2_reg;
    logic [2*AMP_W-1:0]       prod2_reg;
    logic [AMP_W-1:0]         amp2_reg;
    logic                     out_valid_reg;
    logic [15:0]              dac_reg;
    logic [AMP_W-1:0]         amp_out_reg;

    logic [IDX_W-1:0]         rd_idx;
    logic [AMP_W-1:0]         rd_amp;
    logic [SINE_W-1:0]        sine_abs;
    logic [AMP_W-1:0]         q_est;
    logic [AMP_W:0]           q_rem;
    logic [AMP_W-1:0]         quot;
    logic [SAMPLE_W-1:0]      sample;

    assign adv    = !out_valid_reg || out_ready;
    assign pop    = adv && !queue_empty;
    assign rd_idx = queue_data[IDX_W+AMP_W-1:AMP_W];
    assign rd_amp = queue_data[AMP_W-1:0];

    // x / 2047 for x < 2047 * 2048: estimate x >> 11, then one correction step
    always_comb
    begin
        sine_abs = sine1_reg[SINE_W-1] ? SINE_W'(-sine1_reg) : SINE_W'(sine1_reg);
        q_est    = prod2_reg[2*AMP_W-1:AMP_W];
        q_rem    = {1'b0, q_est} + {1'b0, prod2_reg[AMP_W-1:0]};
        quot     = (q_rem >= {1'b0, FULL_AMPLITUDE}) ? q_est + 1'b1 : q_est;
        sample   = neg2_reg ? DAC_MIDSCALE - {1'b0, quot} : DAC_MIDSCALE + {1'b0, quot};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= !queue_empty;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sine1_reg   <= rom_tab[rd_idx];
            amp1_reg    <= rd_amp;
            neg2_reg    <= sine1_reg[SINE_W-1];
            prod2_reg   <= sine_abs[AMP_W-1:0] * amp1_reg;
            amp2_reg    <= amp1_reg;
            dac_reg     <= {cfg.dac_ctrl, sample};
            amp_out_reg <= amp2_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign dac_word          = dac_reg;
    assign current_amplitude = amp_out_reg;

`ifndef SYNTHESIS
    a_sample_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> dac_reg[SAMPLE_W-1:0] != '0)
        else $error("offset sample out of range");
    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v2_reg) && (!v2_reg || $stable(prod2_reg)))
        else $error("pipeline moved while output stalled");
`endif

endmodule

// ===== rtl/dds_tone_with_fade.sv =====
// Top level of the DDS sine tone generator with amplitude fade.
//
//  channel | signals                          | payload
//  --------+----------------------------------+------------------------------------------
//  s_      | s_tvalid s_tready s_tdata s_tuser| tdata: phase_increment, tone_enable; tuser: mode
//  m_      | m_tvalid m_tready m_tdata        | tdata: dac_word, current_amplitude
//  cfg_    | cfg_valid cfg_ready              | cfg_index, cfg_data
//
// One transfer per cycle on each side while s_tready and m_tready are high. m_tvalid for a
// sample rises after the queue, then the sine lookup, multiply and divide-by-2047 registers.
// Reset: phase 0, amplitude 2047, control nibble 3, fade step 103.
// A 4-entry queue absorbs output stalls; s_tready drops only when it is full.
module dds_tone_with_fade
    import dtf_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [39:0]           s_tdata,   // phase_increment[31:0], tone_enable[32], zero pad
    input  logic [0:0]            s_tuser,   // mode[0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // dac_word[15:0], current_amplitude[26:16], zero pad
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int Q_DEPTH = 4;
    localparam int Q_W     = IDX_W + AMP_W;

    dtf_cfg_t         cfg_reg;
    logic             q_push;
    logic [Q_W-1:0]   q_push_data;
    logic             q_pop;
    logic [Q_W-1:0]   q_pop_data;
    logic             q_empty;
    logic             q_full;
    logic [15:0]      dac_word;
    logic [AMP_W-1:0] current_amplitude;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dac_ctrl  <= CTRL_RESET;
            cfg_reg.fade_step <= FADE_STEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DAC_CTRL:  cfg_reg.dac_ctrl  <= cfg_data[CTRL_W-1:0];
                CFG_FADE_STEP: cfg_reg.fade_step <= cfg_data[AMP_W-1:0];
                default:       ;
            endcase
        end
    end

    dtf_front #(
        .IDX_W (IDX_W)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .mode            (s_tuser[0]),
        .phase_increment (s_tdata[PHASE_W-1:0]),
        .tone_enable     (s_tdata[PHASE_W]),
        .cfg             (cfg_reg),
        .queue_full      (q_full),
        .push            (q_push),
        .push_data       (q_push_data)
    );

    dtf_fifo #(
        .WIDTH (Q_W),
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty),
        .full      (q_full)
    );

    dtf_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .queue_empty       (q_empty),
        .queue_data        (q_pop_data),
        .pop               (q_pop),
        .cfg               (cfg_reg),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .dac_word          (dac_word),
        .current_amplitude (current_amplitude)
    );

    assign m_tdata = {5'd0, current_amplitude, dac_word};

endmodule
